>>> hdl/lfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfe_pkg;

	// Field widths
	localparam int POS_W    = 31;
	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = 16;
	localparam int DVD_W    = MAG_W + POS_W;
	localparam int BYTE_W   = 8;

	// Midpoint of 8-bit unsigned samples
	localparam logic [BYTE_W-1:0] MID8 = 8'd128;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Accept to result strobe: queue, two multiply stages, two dividers, output register
	localparam int LATENCY = 2 * MAG_W + 4;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_SIXTEEN_BIT_MODE,
		REG_FADE_IN_END,
		REG_FADE_OUT_START,
		REG_DATA_SIZE
	} reg_index_t;

	typedef struct packed {
		logic             sixteen_bit_mode;
		logic [POS_W-1:0] fade_in_end;
		logic [POS_W-1:0] fade_out_start;
		logic [POS_W-1:0] data_size;
	} cfg_t;

	// One classified sample on its way through the back end
	typedef struct packed {
		logic             beyond;
		logic             mode16;
		logic             neg;
		logic [MAG_W-1:0] mag;
		logic             apply_in;
		logic             apply_out;
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] num_out;
	} entry_t;

endpackage

`default_nettype wire

>>> hdl/lfe_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lfe_front (
	input  wire logic                          start,
	input  wire logic                          full,
	input  wire logic [lfe_pkg::SAMPLE_W-1:0]  sample_in,
	input  wire logic [lfe_pkg::POS_W-1:0]     byte_position,
	input  wire lfe_pkg::cfg_t                 cfg,
	output logic                               push,
	output lfe_pkg::entry_t                    entry
);

	logic                          neg16;
	logic [lfe_pkg::MAG_W-1:0]     mag16;
	logic [lfe_pkg::BYTE_W-1:0]    raw8;
	logic                          neg8;
	logic [lfe_pkg::BYTE_W-1:0]    mag8;

	assign push = start & ~full;

	// Split a 16-bit sample into sign and magnitude
	assign neg16 = sample_in[lfe_pkg::SAMPLE_W-1];
	assign mag16 = neg16 ? (~sample_in + 1'b1) : sample_in;

	// Take an 8-bit sample about its midpoint
	assign raw8 = sample_in[lfe_pkg::BYTE_W-1:0];
	assign neg8 = ~raw8[lfe_pkg::BYTE_W-1];
	assign mag8 = neg8 ? (lfe_pkg::MID8 - raw8) : (raw8 - lfe_pkg::MID8);

	// Classify against the ramp bounds
	always_comb begin
		entry.beyond    = byte_position >= cfg.data_size;
		entry.mode16    = cfg.sixteen_bit_mode;
		entry.neg       = cfg.sixteen_bit_mode ? neg16 : neg8;
		entry.mag       = cfg.sixteen_bit_mode ? mag16
			: {{(lfe_pkg::MAG_W - lfe_pkg::BYTE_W){1'b0}}, mag8};
		entry.apply_in  = byte_position < cfg.fade_in_end;
		entry.apply_out = byte_position >= cfg.fade_out_start;
		entry.pos       = byte_position;
		entry.num_out   = cfg.data_size - byte_position;
	end

endmodule

`default_nettype wire

>>> hdl/lfe_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module lfe_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire lfe_pkg::entry_t   entry_in,
	output logic                   full,
	output logic                   out_valid,
	output lfe_pkg::entry_t        entry_out
);

	lfe_pkg::entry_t                 slots [lfe_pkg::QUEUE_DEPTH];
	logic [lfe_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [lfe_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [lfe_pkg::QCNT_W-1:0]      count_q;
	logic                            pop;

	// The back end takes an entry whenever one is present
	assign out_valid = count_q != '0;
	assign pop       = out_valid;
	assign full      = count_q == lfe_pkg::QCNT_W'(lfe_pkg::QUEUE_DEPTH);
	assign entry_out = slots[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (push)
			slots[wr_ptr_q] <= entry_in;
	end

endmodule

`default_nettype wire

>>> hdl/lfe_div.sv
`timescale 1ns / 1ps
`default_nettype none

module lfe_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        valid_in,
	input  wire logic [lfe_pkg::DVD_W-1:0]   dividend,
	input  wire logic [lfe_pkg::POS_W-1:0]   divisor,
	input  wire lfe_pkg::entry_t             side_in,
	output logic                             valid_out,
	output logic [lfe_pkg::MAG_W-1:0]        quotient,
	output lfe_pkg::entry_t                  side_out
);

	// Restoring division, one quotient bit per stage. The quotient never exceeds
	// the sample magnitude, so the upper dividend bits start below the divisor.
	logic [lfe_pkg::POS_W-1:0] rem_s   [lfe_pkg::MAG_W];
	logic [lfe_pkg::MAG_W-1:0] low_s   [lfe_pkg::MAG_W];
	logic [lfe_pkg::MAG_W-1:0] quo_s   [lfe_pkg::MAG_W];
	lfe_pkg::entry_t           side_s  [lfe_pkg::MAG_W];
	logic                      valid_s [lfe_pkg::MAG_W];

	for (genvar i = 0; i < lfe_pkg::MAG_W; i++) begin : g_stage
		logic [lfe_pkg::POS_W-1:0] rem_prev;
		logic [lfe_pkg::MAG_W-1:0] low_prev;
		logic [lfe_pkg::MAG_W-1:0] quo_prev;
		lfe_pkg::entry_t           side_prev;
		logic                      valid_prev;
		logic [lfe_pkg::POS_W:0]   trial;
		logic                      fits;

		if (i == 0) begin : g_first
			assign rem_prev   = dividend[lfe_pkg::DVD_W-1 -: lfe_pkg::POS_W];
			assign low_prev   = dividend[lfe_pkg::MAG_W-1:0];
			assign quo_prev   = '0;
			assign side_prev  = side_in;
			assign valid_prev = valid_in;
		end else begin : g_next
			assign rem_prev   = rem_s[i-1];
			assign low_prev   = low_s[i-1];
			assign quo_prev   = quo_s[i-1];
			assign side_prev  = side_s[i-1];
			assign valid_prev = valid_s[i-1];
		end

		// Shift in the next dividend bit and try the subtract
		assign trial = {rem_prev, low_prev[lfe_pkg::MAG_W-1]};
		assign fits  = trial >= {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_s[i] <= 1'b0;
			else
				valid_s[i] <= valid_prev;
		end

		always_ff @(posedge clk) begin
			rem_s[i]  <= fits ? (trial[lfe_pkg::POS_W-1:0] - divisor)
				: trial[lfe_pkg::POS_W-1:0];
			low_s[i]  <= {low_prev[lfe_pkg::MAG_W-2:0], 1'b0};
			quo_s[i]  <= {quo_prev[lfe_pkg::MAG_W-2:0], fits};
			side_s[i] <= side_prev;
		end
	end

	assign valid_out = valid_s[lfe_pkg::MAG_W-1];
	assign quotient  = quo_s[lfe_pkg::MAG_W-1];
	assign side_out  = side_s[lfe_pkg::MAG_W-1];

endmodule

`default_nettype wire

>>> hdl/lfe_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lfe_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire lfe_pkg::entry_t               entry,
	input  wire lfe_pkg::cfg_t                 cfg,
	output logic                               done,
	output logic [lfe_pkg::SAMPLE_W-1:0]       sample_out,
	output logic                               beyond_end
);

	logic                          valid_s1;
	lfe_pkg::entry_t               entry_s1;
	logic [lfe_pkg::DVD_W-1:0]     prod_s1;
	logic [lfe_pkg::DVD_W-1:0]     prod1;

	logic                          div1_valid;
	logic [lfe_pkg::MAG_W-1:0]     div1_quo;
	lfe_pkg::entry_t               div1_side;
	lfe_pkg::entry_t               faded_in;

	logic                          valid_s2;
	lfe_pkg::entry_t               entry_s2;
	logic [lfe_pkg::DVD_W-1:0]     prod_s2;
	logic [lfe_pkg::DVD_W-1:0]     prod2;
	logic [lfe_pkg::POS_W-1:0]     den_out;

	logic                          div2_valid;
	logic [lfe_pkg::MAG_W-1:0]     div2_quo;
	lfe_pkg::entry_t               div2_side;
	logic [lfe_pkg::MAG_W-1:0]     mag_final;
	logic [lfe_pkg::MAG_W:0]       signed_val;
	logic [lfe_pkg::MAG_W:0]       biased;
	logic [lfe_pkg::SAMPLE_W-1:0]  result;

	logic                          done_q;
	logic [lfe_pkg::SAMPLE_W-1:0]  sample_out_q;
	logic                          beyond_end_q;

	// Fade-in numerator product
	assign prod1 = entry.mag * entry.pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		entry_s1 <= entry;
		prod_s1  <= prod1;
	end

	lfe_div u_div_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_s1),
		.dividend  (prod_s1),
		.divisor   (cfg.fade_in_end),
		.side_in   (entry_s1),
		.valid_out (div1_valid),
		.quotient  (div1_quo),
		.side_out  (div1_side)
	);

	// Keep the magnitude unchanged where the fade-in does not apply
	always_comb begin
		faded_in     = div1_side;
		faded_in.mag = div1_side.apply_in ? div1_quo : div1_side.mag;
	end

	// Fade-out numerator product
	assign prod2   = faded_in.mag * faded_in.num_out;
	assign den_out = cfg.data_size - cfg.fade_out_start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else
			valid_s2 <= div1_valid;
	end

	always_ff @(posedge clk) begin
		entry_s2 <= faded_in;
		prod_s2  <= prod2;
	end

	lfe_div u_div_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_s2),
		.dividend  (prod_s2),
		.divisor   (den_out),
		.side_in   (entry_s2),
		.valid_out (div2_valid),
		.quotient  (div2_quo),
		.side_out  (div2_side)
	);

	// Restore sign and midpoint
	assign mag_final  = div2_side.apply_out ? div2_quo : div2_side.mag;
	assign signed_val = div2_side.neg ? (~{1'b0, mag_final} + 1'b1) : {1'b0, mag_final};
	assign biased     = signed_val + {{(lfe_pkg::MAG_W + 1 - lfe_pkg::BYTE_W){1'b0}},
		lfe_pkg::MID8};

	always_comb begin
		if (div2_side.beyond)
			result = '0;
		else if (div2_side.mode16)
			result = signed_val[lfe_pkg::SAMPLE_W-1:0];
		else
			result = {{(lfe_pkg::SAMPLE_W - lfe_pkg::BYTE_W){1'b0}},
				biased[lfe_pkg::BYTE_W-1:0]};
	end

	// Drive the result strobe for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= div2_valid;
	end

	always_ff @(posedge clk) begin
		sample_out_q <= result;
		beyond_end_q <= div2_side.beyond;
	end

	assign done       = done_q;
	assign sample_out = sample_out_q;
	assign beyond_end = beyond_end_q;

endmodule

`default_nettype wire

>>> hdl/pcm_linear_fade_envelope_core.sv
// Channel   Signals                               Transaction
// command   start, busy, sample_in, byte_position  start & !busy at clk edge
// result    done, sample_out, beyond_end          done high one cycle, always taken
// config    wr_en, wr_index, wr_data              wr_en at clk edge, no wait
//
// One sample is taken every cycle while busy is low; each result follows its command
// through the queue and two 16-stage restoring dividers, one for each ramp.
// arst_n clears the registers to 16-bit mode with all bounds zero.
// busy rises only if the front queue fills; the back end never stalls.
`timescale 1ns / 1ps
`default_nettype none

module pcm_linear_fade_envelope_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [lfe_pkg::SAMPLE_W-1:0]  sample_in,
	input  wire logic [lfe_pkg::POS_W-1:0]     byte_position,
	input  wire logic                          wr_en,
	input  wire logic [1:0]                    wr_index,
	input  wire logic [lfe_pkg::POS_W-1:0]     wr_data,
	output logic                               done,
	output logic [lfe_pkg::SAMPLE_W-1:0]       sample_out,
	output logic                               beyond_end
);

	lfe_pkg::cfg_t     cfg_q;
	logic              push;
	logic              full;
	lfe_pkg::entry_t   front_entry;
	logic              queue_valid;
	lfe_pkg::entry_t   queue_entry;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sixteen_bit_mode <= 1'b1;
			cfg_q.fade_in_end      <= '0;
			cfg_q.fade_out_start   <= '0;
			cfg_q.data_size        <= '0;
		end else if (wr_en) begin
			case (lfe_pkg::reg_index_t'(wr_index))
				lfe_pkg::REG_SIXTEEN_BIT_MODE: cfg_q.sixteen_bit_mode <= wr_data[0];
				lfe_pkg::REG_FADE_IN_END:      cfg_q.fade_in_end      <= wr_data;
				lfe_pkg::REG_FADE_OUT_START:   cfg_q.fade_out_start   <= wr_data;
				lfe_pkg::REG_DATA_SIZE:        cfg_q.data_size        <= wr_data;
				default: ;
			endcase
		end
	end

	assign busy = full;

	lfe_front u_front (
		.start         (start),
		.full          (full),
		.sample_in     (sample_in),
		.byte_position (byte_position),
		.cfg           (cfg_q),
		.push          (push),
		.entry         (front_entry)
	);

	lfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.entry_in  (front_entry),
		.full      (full),
		.out_valid (queue_valid),
		.entry_out (queue_entry)
	);

	lfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (queue_valid),
		.entry      (queue_entry),
		.cfg        (cfg_q),
		.done       (done),
		.sample_out (sample_out),
		.beyond_end (beyond_end)
	);

`ifndef NO_ASSERTIONS
	// The back end drains the queue every cycle, so it never fills
	a_never_full: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("front queue filled");

	// Every accepted command yields its result after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(lfe_pkg::LATENCY) done)
		else $error("result strobe missing after command");

	// A sample past the end comes out as zero
	a_beyond_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && beyond_end) |-> (sample_out == '0))
		else $error("nonzero sample past end of data");

	// In 8-bit mode the upper byte stays clear
	a_byte_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !cfg_q.sixteen_bit_mode) |->
		(sample_out[lfe_pkg::SAMPLE_W-1:lfe_pkg::BYTE_W] == '0))
		else $error("upper byte set in 8-bit mode");
`endif

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam logic [lfe_pkg::POS_W-1:0] POS_MAX = '1;
	localparam int IDLE_LIMIT = 2000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 60;

	typedef struct {
		logic [lfe_pkg::SAMPLE_W-1:0] sample;
		logic                         beyond;
	} faded_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [lfe_pkg::SAMPLE_W-1:0] sample_in;
	logic [lfe_pkg::POS_W-1:0]    byte_position;
	logic                         wr_en;
	logic [1:0]                   wr_index;
	logic [lfe_pkg::POS_W-1:0]    wr_data;
	logic                         done;
	logic [lfe_pkg::SAMPLE_W-1:0] sample_out;
	logic                         beyond_end;

	// Shadow copy of the fade registers, reset values
	logic                      cfg_mode16 = 1'b1;
	logic [lfe_pkg::POS_W-1:0] cfg_fade_in_end = '0;
	logic [lfe_pkg::POS_W-1:0] cfg_fade_out_start = '0;
	logic [lfe_pkg::POS_W-1:0] cfg_data_size = '0;

	faded_t faded_q[$];
	int     error_count = 0;

	pcm_linear_fade_envelope_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.sample_in    (sample_in),
		.byte_position(byte_position),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.done         (done),
		.sample_out   (sample_out),
		.beyond_end   (beyond_end)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Scale a signed level by num/den, truncating toward zero
	function automatic longint scale_toward_zero(longint level, longint unsigned num,
			longint unsigned den);
		longint unsigned mag;
		longint unsigned q;
		if (den == 0)
			return 0;
		mag = (level < 0) ? -level : level;
		q = (mag * num) / den;
		return (level < 0) ? -longint'(q) : longint'(q);
	endfunction

	// Compute the faded sample for one command under the shadow registers
	function automatic faded_t fade_sample(logic [lfe_pkg::SAMPLE_W-1:0] raw,
			logic [lfe_pkg::POS_W-1:0] pos);
		faded_t r;
		longint level;
		longint mid;
		if (pos >= cfg_data_size) begin
			r.sample = '0;
			r.beyond = 1'b1;
			return r;
		end
		if (cfg_mode16) begin
			mid = 0;
			level = longint'($signed(raw));
		end else begin
			mid = 128;
			level = longint'(raw[7:0]) - 128;
		end
		if (pos < cfg_fade_in_end)
			level = scale_toward_zero(level, longint'(pos), longint'(cfg_fade_in_end));
		if (pos >= cfg_fade_out_start)
			level = scale_toward_zero(level,
				longint'(cfg_data_size) - longint'(pos),
				longint'(cfg_data_size) - longint'(cfg_fade_out_start));
		level = level + mid;
		r.beyond = 1'b0;
		r.sample = cfg_mode16 ? level[15:0] : {8'h00, level[7:0]};
		return r;
	endfunction

	// Issue one command and hold it until the block takes it
	task automatic send_sample(logic [lfe_pkg::SAMPLE_W-1:0] raw,
			logic [lfe_pkg::POS_W-1:0] pos);
		start <= 1'b1;
		sample_in <= raw;
		byte_position <= pos;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		faded_q.push_back(fade_sample(raw, pos));
	endtask

	task automatic idle_burst(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Hold off commands until every outstanding result is back
	task automatic drain_results();
		start <= 1'b0;
		while (faded_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(lfe_pkg::reg_index_t idx, logic [lfe_pkg::POS_W-1:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		case (idx)
			lfe_pkg::REG_SIXTEEN_BIT_MODE: cfg_mode16 = value[0];
			lfe_pkg::REG_FADE_IN_END:      cfg_fade_in_end = value;
			lfe_pkg::REG_FADE_OUT_START:   cfg_fade_out_start = value;
			lfe_pkg::REG_DATA_SIZE:        cfg_data_size = value;
			default: ;
		endcase
	endtask

	task automatic set_config(logic mode16, logic [lfe_pkg::POS_W-1:0] fin,
			logic [lfe_pkg::POS_W-1:0] fout, logic [lfe_pkg::POS_W-1:0] dsize);
		write_reg(lfe_pkg::REG_SIXTEEN_BIT_MODE, {{(lfe_pkg::POS_W-1){1'b0}}, mode16});
		write_reg(lfe_pkg::REG_FADE_IN_END, fin);
		write_reg(lfe_pkg::REG_FADE_OUT_START, fout);
		write_reg(lfe_pkg::REG_DATA_SIZE, dsize);
		wr_en <= 1'b0;
	endtask

	// Reset registers: zero data size puts every sample past the end
	task automatic test_reset_defaults();
		send_sample(16'h7FFF, '0);
		send_sample(16'h8000, POS_MAX);
		send_sample(16'h1234, 31'd5);
		drain_results();
	endtask

	// Unity gain up to the end of data, extreme sample codes, one sample past the end
	task automatic test_full_gain();
		set_config(1'b1, '0, POS_MAX, POS_MAX);
		send_sample(16'h7FFF, '0);
		send_sample(16'h8000, 31'd1);
		send_sample(16'hFFFF, POS_MAX - 31'd1);
		send_sample(16'h0001, 31'd12345);
		send_sample(16'h0000, 31'd100);
		send_sample(16'h8000, POS_MAX);
		drain_results();
	endtask

	// Unsigned bytes about 128, upper bits ignored, both ramp edges
	task automatic test_eight_bit_fades();
		set_config(1'b0, 31'd1000, 31'd5000, 31'd6000);
		send_sample(16'h00FF, 31'd0);
		send_sample(16'h0000, 31'd500);
		send_sample(16'hAB80, 31'd999);
		send_sample(16'hFF00, 31'd1000);
		send_sample(16'h12FF, 31'd5000);
		send_sample(16'h0001, 31'd5999);
		send_sample(16'h0000, 31'd5500);
		send_sample(16'h00FF, 31'd6000);
		drain_results();
	endtask

	// Fade-in result feeds the fade-out where the ramps overlap
	task automatic test_overlapping_ramps();
		set_config(1'b1, 31'd4000, 31'd100, 31'd5000);
		send_sample(16'h8000, 31'd2000);
		send_sample(16'h7FFF, 31'd4500);
		send_sample(16'hC000, 31'd3999);
		send_sample(16'h7FFF, 31'd100);
		drain_results();
	endtask

	// Fade-out start past data size: the fade-out never engages
	task automatic test_fade_out_beyond_end();
		set_config(1'b1, '0, 31'd9000, 31'd8000);
		send_sample(16'h8000, 31'd7999);
		send_sample(16'h7FFF, 31'd0);
		send_sample(16'h1234, 31'd8000);
		drain_results();
	endtask

	// Random streams over several register settings, drained between phases
	task automatic test_random_stream();
		logic                         mode16;
		logic [lfe_pkg::POS_W-1:0]    dsize;
		logic [lfe_pkg::POS_W-1:0]    fin;
		logic [lfe_pkg::POS_W-1:0]    fout;
		logic [lfe_pkg::POS_W-1:0]    pos;
		logic [lfe_pkg::POS_W-1:0]    edge_pos;
		logic [lfe_pkg::SAMPLE_W-1:0] raw;
		longint                       near;
		for (int phase = 0; phase < PHASES; phase++) begin
			// Pick the settings; open with the widest ramps in both modes
			if (phase < 2) begin
				mode16 = phase[0];
				fin = POS_MAX;
				fout = '0;
				dsize = POS_MAX;
			end else begin
				mode16 = 1'($urandom_range(0, 1));
				case ($urandom_range(0, 4))
					0: dsize = POS_MAX;
					1: dsize = 31'($urandom_range(1, 64));
					2: dsize = 31'($urandom_range(65, 1 << 20));
					3: dsize = 31'($urandom);
					default: dsize = '0;
				endcase
				case ($urandom_range(0, 3))
					0: fin = '0;
					1: fin = POS_MAX;
					default: fin = 31'($urandom % (longint'(dsize) + 1));
				endcase
				case ($urandom_range(0, 3))
					0: fout = '0;
					1: fout = 31'(longint'(dsize) + longint'($urandom_range(1, 16)));
					default: fout = 31'($urandom % (longint'(dsize) + 1));
				endcase
			end
			set_config(mode16, fin, fout, dsize);

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Sample: mostly random, some extreme codes
				case ($urandom_range(0, 15))
					0: raw = 16'h0000;
					1: raw = 16'h7FFF;
					2: raw = 16'h8000;
					3: raw = 16'hFFFF;
					4: raw = {8'($urandom_range(0, 255)), 8'h80};
					5: raw = {8'($urandom_range(0, 255)), 8'h7F};
					default: raw = 16'($urandom_range(0, 65535));
				endcase
				// Position: mostly inside the stream, some at ramp edges, some anywhere
				case ($urandom_range(0, 19))
					0, 1, 2: pos = 31'($urandom);
					3, 4, 5, 6: begin
						case ($urandom_range(0, 2))
							0: edge_pos = cfg_fade_in_end;
							1: edge_pos = cfg_fade_out_start;
							default: edge_pos = cfg_data_size;
						endcase
						near = longint'(edge_pos) + longint'($urandom_range(0, 4)) - 2;
						pos = near[lfe_pkg::POS_W-1:0];
					end
					default: pos = 31'($urandom % (longint'(cfg_data_size) + 1));
				endcase
				// Insert gaps except in the last phase
				if (phase < PHASES - 1 && $urandom_range(0, 7) == 0)
					idle_burst($urandom_range(1, 18));
				send_sample(raw, pos);
			end
			drain_results();
		end
	endtask

	// Compare each result against the oldest outstanding transaction
	always @(posedge clk) begin
		faded_t want;
		if (arst_n === 1'b1 && done !== 1'b0) begin
			if (faded_q.size() == 0) begin
				$error("unexpected result: sample_out=%h beyond_end=%b", sample_out,
					beyond_end);
				error_count++;
			end else begin
				want = faded_q.pop_front();
				if (done !== 1'b1) begin
					$error("done: expected 1, actual %b", done);
					error_count++;
				end
				if (sample_out !== want.sample) begin
					$error("sample_out: expected %h, actual %h", want.sample, sample_out);
					error_count++;
				end
				if (beyond_end !== want.beyond) begin
					$error("beyond_end: expected %b, actual %b", want.beyond, beyond_end);
					error_count++;
				end
			end
		end
	end

	// Abort when no transaction moves for too long
	initial begin
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		sample_in <= '0;
		byte_position <= '0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_full_gain();
		test_eight_bit_fades();
		test_overlapping_ramps();
		test_fade_out_beyond_end();
		test_random_stream();

		// Let any stray result surface before the verdict
		drain_results();
		repeat (lfe_pkg::LATENCY + 8) @(posedge clk);
		if (faded_q.size() != 0) begin
			$error("%0d results never arrived", faded_q.size());
			error_count++;
		end
		if (error_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

>>> files.f
hdl/lfe_pkg.sv
hdl/lfe_front.sv
hdl/lfe_queue.sv
hdl/lfe_div.sv
hdl/lfe_back.sv
hdl/pcm_linear_fade_envelope_core.sv
verif/tb_top.sv
